>>> design/arrs_pkg.sv
// Shared types and codes for the affinity round-robin scheduler.
package arrs_pkg;

   localparam int TASK_W = 4;
   localparam int AFF_W  = 2;

   // Operation codes carried in the mode field
   localparam logic [1:0] MODE_READY = 2'd0;
   localparam logic [1:0] MODE_SCHED = 2'd1;
   localparam logic [1:0] MODE_KILL  = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_DENIED    = 2'd1;
   localparam logic [1:0] STATUS_NOT_ALIVE = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   // Task ids with fixed roles
   localparam logic [TASK_W-1:0] TASK_IDLE = 4'd0;
   localparam logic [TASK_W-1:0] TASK_INIT = 4'd1;

   typedef struct packed {
      logic [1:0]        mode;
      logic [TASK_W-1:0] task_id;
      logic [AFF_W-1:0]  affinity;
      logic              core;
      logic              still_running;
   } req_word_type;

   typedef struct packed {
      logic [TASK_W-1:0] next_task;
      logic              from_queue;
      logic              requeued;
      logic [1:0]        status;
   } rsp_word_type;

   // Source of the chosen task
   typedef enum logic [1:0] {
      NEXT_HOLD,
      NEXT_FOUND,
      NEXT_KEEP
   } next_sel_type;

   // Which id a search looks for or an append writes
   typedef enum logic {
      KEY_TASK,
      KEY_CUR
   } key_sel_type;

   typedef struct packed {
      logic         load_item;
      logic         scan_clear;
      logic         scan_run;
      logic         scan_aff;
      key_sel_type  key_sel;
      logic         latch_cur;
      logic         shift_clear;
      logic         shift_run;
      logic         count_dec;
      logic         append;
      logic         aff_write;
      logic         alive_set;
      logic         alive_clr;
      next_sel_type next_sel;
      logic         set_fromq;
      logic         set_req;
      logic         set_status;
      logic [1:0]   status_val;
      logic         set_current;
      logic         out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       id_zero;
      logic       id_one;
      logic       id_ok;
      logic       id_alive;
      logic       scan_hit;
      logic       scan_end;
      logic       shift_done;
      logic       queue_full;
      logic       requeue_need;
      logic       rsp_busy;
   } dp_stat_type;

endpackage

>>> design/arrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arrs_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/arrs_dp.sv
// Scheduler datapath: ready queue, task tables, search and shift pipelines.
module arrs_dp #(
   parameter int MAX_TASKS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  arrs_pkg::req_word_type req_word,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output arrs_pkg::rsp_word_type rsp_word,
   input  arrs_pkg::dp_cmd_type   cmd,
   output arrs_pkg::dp_stat_type  stat
);

   import arrs_pkg::*;

   localparam int QDEPTH = MAX_TASKS - 1;
   localparam int CNT_W  = $clog2(MAX_TASKS);
   localparam int POS_W  = CNT_W + 1;
   localparam int QIDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int TIDX_W = $clog2(MAX_TASKS);

   function automatic logic id_ok(input logic [TASK_W-1:0] id);
      return 8'(id) < 8'(MAX_TASKS);
   endfunction

   req_word_type      item_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [MAX_TASKS-1:0] alive_ff;
   logic [TASK_W-1:0] core_current_ff [2];

   // search pipeline
   logic [POS_W-1:0]  issue_ff;
   logic              s1_valid_ff;
   logic [POS_W-1:0]  s1_pos_ff;
   logic              s2_valid_ff;
   logic [POS_W-1:0]  s2_pos_ff;
   logic [TASK_W-1:0] s2_id_ff;

   // shift pipeline for removal
   logic [POS_W-1:0]  sh_rd_ff;
   logic              sh_wv_ff;
   logic [POS_W-1:0]  sh_wpos_ff;

   // current task of the scheduled core
   logic [TASK_W-1:0] cur_ff;
   logic              running_ff;
   logic              keep_ff;

   // result under construction and output word
   logic [TASK_W-1:0] next_ff;
   logic              fromq_ff;
   logic              req_ff;
   logic [1:0]        status_ff;
   rsp_word_type      rsp_word_ff;
   logic              rsp_valid_ff;

   logic [TASK_W-1:0] list_rd;
   logic [AFF_W-1:0]  aff_rd;
   logic              list_wr_en;
   logic [QIDX_W-1:0] list_wr_addr;
   logic [TASK_W-1:0] list_wr_data;
   logic [QIDX_W-1:0] list_rd_addr;
   logic [TIDX_W-1:0] aff_rd_addr;
   logic [TASK_W-1:0] key_id;
   logic [TASK_W-1:0] cur_now;
   logic [POS_W-1:0]  count_pos;
   logic              s2_in_range;
   logic              match;
   logic              hit;
   logic              running_now;

   assign count_pos = {1'b0, count_ff};
   assign key_id    = (cmd.key_sel == KEY_CUR) ? cur_ff : item_ff.task_id;
   assign cur_now   = core_current_ff[item_ff.core];

   // Memory ports
   assign list_rd_addr = cmd.shift_run ? QIDX_W'(sh_rd_ff) : QIDX_W'(issue_ff);
   assign list_wr_en   = sh_wv_ff || cmd.append;
   assign list_wr_addr = sh_wv_ff ? QIDX_W'(sh_wpos_ff) : QIDX_W'(count_ff);
   assign list_wr_data = sh_wv_ff ? list_rd : key_id;
   assign aff_rd_addr  = cmd.scan_run ? TIDX_W'(list_rd) : TIDX_W'(cur_now);

   arrs_ram #(.WIDTH(TASK_W), .DEPTH(QDEPTH)) u_list (
      .clock   (clock),
      .wr_en   (list_wr_en),
      .wr_addr (list_wr_addr),
      .wr_data (list_wr_data),
      .rd_addr (list_rd_addr),
      .rd_data (list_rd)
   );

   arrs_ram #(.WIDTH(AFF_W), .DEPTH(MAX_TASKS)) u_aff (
      .clock   (clock),
      .wr_en   (cmd.aff_write),
      .wr_addr (TIDX_W'(item_ff.task_id)),
      .wr_data (item_ff.affinity),
      .rd_addr (aff_rd_addr),
      .rd_data (aff_rd)
   );

   // Search result at the last pipeline stage
   assign s2_in_range = s2_valid_ff && (s2_pos_ff < count_pos);
   assign match       = cmd.scan_aff ? aff_rd[item_ff.core] : (s2_id_ff == key_id);
   assign hit         = s2_in_range && match;

   assign running_now = (cur_now != TASK_IDLE) && id_ok(cur_now) && item_ff.still_running
                        && alive_ff[TIDX_W'(cur_now)];

   // Status to the controller
   always_comb begin
      stat.mode         = item_ff.mode;
      stat.id_zero      = (item_ff.task_id == TASK_IDLE);
      stat.id_one       = (item_ff.task_id == TASK_INIT);
      stat.id_ok        = id_ok(item_ff.task_id);
      stat.id_alive     = alive_ff[TIDX_W'(item_ff.task_id)];
      stat.scan_hit     = hit;
      stat.scan_end     = s2_valid_ff && !s2_in_range;
      stat.shift_done   = !(sh_rd_ff < count_pos) && !sh_wv_ff;
      stat.queue_full   = (count_ff >= CNT_W'(QDEPTH));
      stat.requeue_need = running_ff && (cur_ff != next_ff);
      stat.rsp_busy     = rsp_valid_ff && rsp_stall;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff           <= '0;
         alive_ff           <= '0;
         core_current_ff[0] <= TASK_IDLE;
         core_current_ff[1] <= TASK_IDLE;
         s1_valid_ff        <= 1'b0;
         s2_valid_ff        <= 1'b0;
         sh_wv_ff           <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         // queue length
         if (cmd.append) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.count_dec) begin
            count_ff <= count_ff - CNT_W'(1);
         end
         // alive flags
         if (cmd.alive_set) begin
            alive_ff[TIDX_W'(item_ff.task_id)] <= 1'b1;
         end else if (cmd.alive_clr) begin
            alive_ff[TIDX_W'(item_ff.task_id)] <= 1'b0;
         end
         if (cmd.set_current) begin
            core_current_ff[item_ff.core] <= next_ff;
         end
         // search stage valids
         if (cmd.scan_clear) begin
            s1_valid_ff <= 1'b0;
            s2_valid_ff <= 1'b0;
         end else if (cmd.scan_run) begin
            s1_valid_ff <= 1'b1;
            s2_valid_ff <= s1_valid_ff;
         end
         // shift write stage
         if (cmd.shift_clear) begin
            sh_wv_ff <= 1'b0;
         end else if (cmd.shift_run) begin
            sh_wv_ff <= (sh_rd_ff < count_pos);
         end
         // output word handshake
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff   <= req_word;
         next_ff   <= TASK_IDLE;
         fromq_ff  <= 1'b0;
         req_ff    <= 1'b0;
         status_ff <= STATUS_OK;
      end else begin
         case (cmd.next_sel)
            NEXT_FOUND: next_ff <= s2_id_ff;
            NEXT_KEEP:  next_ff <= keep_ff ? cur_ff : TASK_IDLE;
            default:    next_ff <= next_ff;
         endcase
         if (cmd.set_fromq) begin
            fromq_ff <= 1'b1;
         end
         if (cmd.set_req) begin
            req_ff <= 1'b1;
         end
         if (cmd.set_status) begin
            status_ff <= cmd.status_val;
         end
      end
      // search pipeline positions
      if (cmd.scan_clear) begin
         issue_ff <= '0;
      end else if (cmd.scan_run) begin
         issue_ff  <= issue_ff + POS_W'(1);
         s1_pos_ff <= issue_ff;
         s2_pos_ff <= s1_pos_ff;
         s2_id_ff  <= list_rd;
      end
      // shift: read entry i+1, write it to i in the following cycle
      if (cmd.shift_clear) begin
         sh_rd_ff <= s2_pos_ff + POS_W'(1);
      end else if (cmd.shift_run && (sh_rd_ff < count_pos)) begin
         sh_wpos_ff <= sh_rd_ff - POS_W'(1);
         sh_rd_ff   <= sh_rd_ff + POS_W'(1);
      end
      // current task snapshot for the scheduled core
      if (cmd.latch_cur) begin
         cur_ff     <= cur_now;
         running_ff <= running_now;
         keep_ff    <= running_now && aff_rd[item_ff.core];
      end
      if (cmd.out_load) begin
         rsp_word_ff.next_task  <= next_ff;
         rsp_word_ff.from_queue <= fromq_ff;
         rsp_word_ff.requeued   <= req_ff;
         rsp_word_ff.status     <= status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

>>> design/arrs_ctrl.sv
// Scheduler controller: sequences search, removal, append and result words.
module arrs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  arrs_pkg::dp_stat_type  stat,
   output arrs_pkg::dp_cmd_type   cmd
);

   import arrs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_R_SCAN,
      ST_S_CUR,
      ST_S_SCAN,
      ST_SHIFT,
      ST_REQ_CHK,
      ST_Q_SCAN,
      ST_COMMIT,
      ST_K_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   // Next state and datapath commands
   always_comb begin
      cmd         = '0;
      cmd.key_sel = KEY_TASK;
      cmd.next_sel = NEXT_HOLD;
      state_in    = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.scan_clear = 1'b1;
            unique case (stat.mode)
               MODE_READY: begin
                  if (stat.id_zero || !stat.id_ok) begin
                     cmd.set_status = 1'b1;
                     cmd.status_val = STATUS_DENIED;
                     state_in       = ST_FINISH;
                  end else begin
                     state_in = ST_R_SCAN;
                  end
               end
               MODE_SCHED: state_in = ST_S_CUR;
               MODE_KILL: begin
                  if (stat.id_one) begin
                     cmd.set_status = 1'b1;
                     cmd.status_val = STATUS_DENIED;
                     state_in       = ST_FINISH;
                  end else if (!stat.id_ok || !stat.id_alive) begin
                     cmd.set_status = 1'b1;
                     cmd.status_val = STATUS_NOT_ALIVE;
                     state_in       = ST_FINISH;
                  end else begin
                     state_in = ST_K_SCAN;
                  end
               end
               default: state_in = ST_FINISH;
            endcase
         end
         // make ready: look for the task already queued
         ST_R_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_hit) begin
               cmd.aff_write = 1'b1;
               cmd.alive_set = 1'b1;
               state_in      = ST_FINISH;
            end else if (stat.scan_end) begin
               if (stat.queue_full) begin
                  cmd.set_status = 1'b1;
                  cmd.status_val = STATUS_FULL;
               end else begin
                  cmd.append    = 1'b1;
                  cmd.aff_write = 1'b1;
                  cmd.alive_set = 1'b1;
               end
               state_in = ST_FINISH;
            end
         end
         // schedule: snapshot the core's current task
         ST_S_CUR: begin
            cmd.latch_cur = 1'b1;
            state_in      = ST_S_SCAN;
         end
         // schedule: first queued task allowed on the core
         ST_S_SCAN: begin
            cmd.scan_run = 1'b1;
            cmd.scan_aff = 1'b1;
            if (stat.scan_hit) begin
               cmd.next_sel    = NEXT_FOUND;
               cmd.set_fromq   = 1'b1;
               cmd.shift_clear = 1'b1;
               state_in        = ST_SHIFT;
            end else if (stat.scan_end) begin
               cmd.next_sel = NEXT_KEEP;
               state_in     = ST_REQ_CHK;
            end
         end
         // close the gap left by the removed entry
         ST_SHIFT: begin
            cmd.shift_run = 1'b1;
            if (stat.shift_done) begin
               cmd.count_dec = 1'b1;
               state_in      = (stat.mode == MODE_SCHED) ? ST_REQ_CHK : ST_FINISH;
            end
         end
         ST_REQ_CHK: begin
            cmd.scan_clear = 1'b1;
            state_in       = stat.requeue_need ? ST_Q_SCAN : ST_COMMIT;
         end
         // requeue the displaced task unless already queued
         ST_Q_SCAN: begin
            cmd.scan_run = 1'b1;
            cmd.key_sel  = KEY_CUR;
            if (stat.scan_hit) begin
               state_in = ST_COMMIT;
            end else if (stat.scan_end) begin
               if (stat.queue_full) begin
                  cmd.set_status = 1'b1;
                  cmd.status_val = STATUS_FULL;
               end else begin
                  cmd.append  = 1'b1;
                  cmd.set_req = 1'b1;
               end
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.set_current = 1'b1;
            state_in        = ST_FINISH;
         end
         // kill: drop the task from the queue if present
         ST_K_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_hit) begin
               cmd.alive_clr   = 1'b1;
               cmd.shift_clear = 1'b1;
               state_in        = ST_SHIFT;
            end else if (stat.scan_end) begin
               cmd.alive_clr = 1'b1;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> design/affinity_round_robin_scheduler.sv
// Two-core round-robin scheduler with per-task affinity: top level.
// One word at a time. A kill that hits ends its search there and the removal
// shift covers the rest of the queue. The search and the shift both use the
// single read port of the ready-list RAM. Synchronous reset empties the queue,
// clears all alive flags and sets both cores to the idle task.
module affinity_round_robin_scheduler #(
   parameter int MAX_TASKS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  arrs_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output arrs_pkg::rsp_word_type rsp_word
);

   import arrs_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   arrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   arrs_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the two-core affinity round-robin scheduler.
`timescale 1ns / 100ps

module testbench;
   import arrs_pkg::*;

   localparam int MAX_TASKS = 16;
   localparam int QUEUE_DEPTH = MAX_TASKS - 1;
   localparam int TAIL_CYCLES = 64;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [1:0] AFF_NONE = 2'b00;
   localparam logic [1:0] AFF_CORE0 = 2'b01;
   localparam logic [1:0] AFF_CORE1 = 2'b10;
   localparam logic [1:0] AFF_BOTH = 2'b11;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   // Receiver stall sources: per-word pacing and the long hold-off
   logic pace_stall = 1'b0;
   logic hold_long = 1'b0;
   assign rsp_stall = pace_stall || hold_long;

   // Pacing switches for the two sides
   bit tx_idle = 1'b0;
   bit rx_idle = 1'b0;
   int hold_request = 0;

   int mismatch_count = 0;
   int words_checked = 0;

   // Scheduler shadow state
   logic [TASK_W-1:0] ready_q[$];
   logic [AFF_W-1:0]  aff_of[MAX_TASKS];
   bit                alive_of[MAX_TASKS];
   logic [TASK_W-1:0] running_on[2];

   // Expected result words, oldest first
   rsp_word_type sched_outcomes[$];

   affinity_round_robin_scheduler #(
      .MAX_TASKS(MAX_TASKS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #(10_000_000);
      $display("testbench NOT OK");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t: word %0d: %s", $realtime, words_checked, msg);
      mismatch_count++;
   endtask

   function automatic int queued_at(input logic [TASK_W-1:0] id);
      int pos;
      pos = -1;
      foreach (ready_q[i])
         if (pos < 0 && ready_q[i] == id) pos = i;
      return pos;
   endfunction

   // Applies one word to the shadow state and returns the result it owes
   function automatic rsp_word_type scheduler_outcome(input req_word_type w);
      rsp_word_type      r;
      int                hit;
      logic [TASK_W-1:0] cur;
      logic [AFF_W-1:0]  core_bit;
      bit                runs;
      r = '0;
      case (w.mode)
         MODE_READY: begin
            if (w.task_id == TASK_IDLE) begin
               r.status = STATUS_DENIED;
            end else if (queued_at(w.task_id) >= 0) begin
               aff_of[w.task_id] = w.affinity;
               alive_of[w.task_id] = 1'b1;
            end else if (ready_q.size() < QUEUE_DEPTH) begin
               ready_q.push_back(w.task_id);
               aff_of[w.task_id] = w.affinity;
               alive_of[w.task_id] = 1'b1;
            end else begin
               r.status = STATUS_FULL;
            end
         end
         MODE_SCHED: begin
            core_bit = AFF_CORE0 << w.core;
            cur = running_on[w.core];
            runs = cur != TASK_IDLE && w.still_running && alive_of[cur];
            // first queued task allowed on this core
            hit = -1;
            foreach (ready_q[i])
               if (hit < 0 && (aff_of[ready_q[i]] & core_bit) != AFF_NONE) hit = i;
            if (hit >= 0) begin
               r.next_task = ready_q[hit];
               ready_q.delete(hit);
               r.from_queue = 1'b1;
            end else if (runs && (aff_of[cur] & core_bit) != AFF_NONE) begin
               r.next_task = cur;
            end else begin
               r.next_task = TASK_IDLE;
            end
            // preempted task goes to the tail unless already queued
            if (runs && cur != r.next_task && queued_at(cur) < 0) begin
               if (ready_q.size() < QUEUE_DEPTH) begin
                  ready_q.push_back(cur);
                  r.requeued = 1'b1;
               end else begin
                  r.status = STATUS_FULL;
               end
            end
            running_on[w.core] = r.next_task;
         end
         MODE_KILL: begin
            if (w.task_id == TASK_INIT) begin
               r.status = STATUS_DENIED;
            end else if (!alive_of[w.task_id]) begin
               r.status = STATUS_NOT_ALIVE;
            end else begin
               hit = queued_at(w.task_id);
               if (hit >= 0) ready_q.delete(hit);
               alive_of[w.task_id] = 1'b0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic req_word_type make_word(input logic [1:0] mode,
                                              input int id, input logic [1:0] aff,
                                              input logic core, input logic run);
      req_word_type w;
      w.mode = mode;
      w.task_id = id[TASK_W-1:0];
      w.affinity = aff;
      w.core = core;
      w.still_running = run;
      return w;
   endfunction

   // Random word; 3 of 100 use the unused mode, the rest after ready and schedule goes to kill
   function automatic req_word_type random_word(input int pct_ready, input int pct_sched);
      req_word_type w;
      int           roll;
      roll = $urandom_range(0, 99);
      w.task_id = TASK_W'($urandom_range(0, 15));
      w.affinity = AFF_W'($urandom_range(0, 3));
      w.core = 1'($urandom_range(0, 1));
      w.still_running = $urandom_range(0, 3) != 0;
      if (roll < 3)
         w.mode = MODE_UNUSED;
      else if (roll < 3 + pct_ready)
         w.mode = MODE_READY;
      else if (roll < 3 + pct_ready + pct_sched)
         w.mode = MODE_SCHED;
      else
         w.mode = MODE_KILL;
      return w;
   endfunction

   // Offers one word after an optional gap; valid stays high once accepted
   task automatic send_word(input req_word_type w);
      int gap;
      gap = tx_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sched_outcomes.push_back(scheduler_outcome(w));
   endtask

   // Receiver pacing: wait some cycles, then take one word
   always begin : rsp_pacing
      int hold;
      hold = rx_idle ? $urandom_range(0, 19) : 0;
      if (hold > 0) begin
         pace_stall <= 1'b1;
         repeat (hold) @(posedge clock);
      end
      pace_stall <= 1'b0;
      @(posedge clock);
      while (!(rsp_valid && !rsp_stall)) @(posedge clock);
   end

   // Long receiver hold-off, counted here
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_long <= 1'b1;
            repeat (hold_request) @(posedge clock);
            hold_long <= 1'b0;
            hold_request = 0;
         end
      end
   end

   // Result check against the oldest expectation
   always @(posedge clock) begin : rsp_check
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sched_outcomes.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", rsp_word));
         end else begin
            want = sched_outcomes.pop_front();
            if (rsp_word.next_task !== want.next_task)
               report_mismatch($sformatf("next_task %h, want %h",
                                         rsp_word.next_task, want.next_task));
            if (rsp_word.from_queue !== want.from_queue)
               report_mismatch($sformatf("from_queue %b, want %b",
                                         rsp_word.from_queue, want.from_queue));
            if (rsp_word.requeued !== want.requeued)
               report_mismatch($sformatf("requeued %b, want %b",
                                         rsp_word.requeued, want.requeued));
            if (rsp_word.status !== want.status)
               report_mismatch($sformatf("status %h, want %h",
                                         rsp_word.status, want.status));
         end
         words_checked++;
      end
   end

   // Denied ids, dead kills, the unused mode and an empty schedule
   task automatic test_denials;
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      send_word(make_word(MODE_READY, 0, AFF_BOTH, 1'b0, 1'b1));
      send_word(make_word(MODE_KILL, 1, AFF_NONE, 1'b0, 1'b0));
      send_word(make_word(MODE_KILL, 5, AFF_NONE, 1'b1, 1'b0));
      send_word(make_word(MODE_KILL, 0, AFF_BOTH, 1'b0, 1'b1));
      send_word(make_word(MODE_UNUSED, 15, AFF_BOTH, 1'b1, 1'b1));
      send_word(make_word(MODE_SCHED, 0, AFF_NONE, 1'b0, 1'b1));
   endtask

   // Affinity choice, keep, requeue, kill of current and queued tasks
   task automatic test_affinity_choice;
      tx_idle = 1'b0;
      rx_idle = 1'b1;
      send_word(make_word(MODE_READY, 15, AFF_BOTH, 1'b0, 1'b0));
      send_word(make_word(MODE_READY, 1, AFF_CORE1, 1'b0, 1'b0));
      send_word(make_word(MODE_READY, 2, AFF_CORE0, 1'b1, 1'b1));
      send_word(make_word(MODE_READY, 3, AFF_NONE, 1'b0, 1'b0));
      // re-ready of a queued task only updates its mask
      send_word(make_word(MODE_READY, 1, AFF_BOTH, 1'b0, 1'b0));
      send_word(make_word(MODE_SCHED, 0, AFF_NONE, 1'b1, 1'b1));
      send_word(make_word(MODE_SCHED, 0, AFF_NONE, 1'b0, 1'b1));
      send_word(make_word(MODE_SCHED, 0, AFF_NONE, 1'b1, 1'b1));
      send_word(make_word(MODE_SCHED, 0, AFF_NONE, 1'b0, 1'b1));
      // kill the task running on core 0; it must not come back
      send_word(make_word(MODE_KILL, 2, AFF_NONE, 1'b0, 1'b0));
      send_word(make_word(MODE_SCHED, 0, AFF_NONE, 1'b0, 1'b1));
      send_word(make_word(MODE_SCHED, 0, AFF_NONE, 1'b1, 1'b0));
      send_word(make_word(MODE_READY, 14, AFF_BOTH, 1'b0, 1'b0));
      send_word(make_word(MODE_READY, 9, AFF_CORE1, 1'b0, 1'b0));
      // kill from the middle of the queue
      send_word(make_word(MODE_KILL, 14, AFF_NONE, 1'b0, 1'b0));
      send_word(make_word(MODE_KILL, 3, AFF_NONE, 1'b0, 1'b0));
      send_word(make_word(MODE_SCHED, 0, AFF_NONE, 1'b1, 1'b1));
   endtask

   // Receiver holds off while the sender keeps offering words
   task automatic test_backpressure;
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      hold_request = 300;
      repeat (40) send_word(random_word(45, 40));
   endtask

   // Random traffic in phases that fill, drain and mix the queue
   task automatic test_random_mix;
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      repeat (300) send_word(random_word(60, 30));
      repeat (300) send_word(random_word(15, 65));
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      repeat (400) send_word(random_word(40, 40));
      tx_idle = 1'b1;
      repeat (330) send_word(random_word(50, 35));
      tx_idle = 1'b0;
      rx_idle = 1'b1;
      repeat (330) send_word(random_word(35, 45));
   endtask

   initial begin
      foreach (aff_of[i]) aff_of[i] = AFF_NONE;
      foreach (alive_of[i]) alive_of[i] = 1'b0;
      running_on[0] = TASK_IDLE;
      running_on[1] = TASK_IDLE;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_denials();
      test_affinity_choice();
      test_backpressure();
      test_random_mix();
      req_valid <= 1'b0;
      while (sched_outcomes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
